// File: rtl/evs_pkg.sv
// ----------------------------------------------------------------------------
// EEVDF scheduler package
// Shared sizes, command codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package evs_pkg;

  localparam int NUM_TASKS = 64;
  localparam int TASK_AW   = $clog2(NUM_TASKS);
  localparam int CNT_W     = $clog2(NUM_TASKS + 1);

  // charge dividend is runtime (48) times weight total (23)
  localparam int DIV_W  = 71;
  localparam int DIV_CW = $clog2(DIV_W + 1);

  localparam logic [1:0] KIND_ENQ  = 2'd0;
  localparam logic [1:0] KIND_DEQ  = 2'd1;
  localparam logic [1:0] KIND_CHG  = 2'd2;
  localparam logic [1:0] KIND_PICK = 2'd3;

  localparam logic [1:0] STS_DONE  = 2'd0;
  localparam logic [1:0] STS_IGN   = 2'd1;
  localparam logic [1:0] STS_EMPTY = 2'd2;

  localparam logic CFG_SLICE = 1'b0;
  localparam logic CFG_LAT   = 1'b1;

  localparam logic [31:0] SLICE_RST = 32'd1024000000;
  localparam logic [31:0] LAT_RST   = 32'd1000000;

  typedef struct packed {
    logic load_in;
    logic rd_scan;
    logic rd_best;
    logic scan_init;
    logic dec;
    logic enq_dec;
    logic enq_fin;
    logic deq_do;
    logic mul_lo;
    logic mul_hi;
    logic div_start;
    logic div_chg;
    logic chg_fin;
    logic pick_sel;
    logic pick_do;
    logic set_ign;
    logic set_empty;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       id_ok;
    logic       queued;
    logic       w_in_zero;
    logic       wt_zero;
    logic       div_done;
    logic       scan_done;
    logic       pick_found;
  } dp_sts_t;

endpackage

// File: rtl/evs_div.sv
// ----------------------------------------------------------------------------
// EEVDF scheduler divider
// Restoring radix-2 divider, one quotient bit per cycle, low 64 bits kept.
// ----------------------------------------------------------------------------
module evs_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [evs_pkg::DIV_W-1:0]   dividend,
  input  logic [16:0]                 divisor,
  output logic                        done,
  output logic [63:0]                 quot
);

  logic                        busy_r;
  logic                        done_r;
  logic [evs_pkg::DIV_CW-1:0]  cnt_r;
  logic [evs_pkg::DIV_W-1:0]   dvd_r;
  logic [16:0]                 rem_r;
  logic [16:0]                 dsr_r;
  logic [63:0]                 quo_r;
  logic [17:0]                 trial;
  logic                        ge;

  always_comb begin
    trial = {rem_r, dvd_r[evs_pkg::DIV_W-1]};
    ge    = (trial >= {1'b0, dsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == evs_pkg::DIV_CW'(evs_pkg::DIV_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[evs_pkg::DIV_W-2:0], 1'b0};
      rem_r <= ge ? 17'(trial - {1'b0, dsr_r}) : trial[16:0];
      quo_r <= {quo_r[62:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

// File: rtl/evs_dp.sv
// ----------------------------------------------------------------------------
// EEVDF scheduler datapath
// Task table memories, queue bits, totals, multiplier, scan and result regs.
// ----------------------------------------------------------------------------
module evs_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  evs_pkg::dp_cmd_t      cmd,
  output evs_pkg::dp_sts_t      sts,
  input  logic [1:0]            in_kind,
  input  logic [5:0]            in_task_id,
  input  logic [16:0]           in_weight,
  input  logic [47:0]           in_runtime,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [31:0]           cfg_wdata,
  output logic [1:0]            out_status,
  output logic [5:0]            out_picked_task,
  output logic [63:0]           out_picked_deadline
);

  localparam int AW = evs_pkg::TASK_AW;
  localparam int N  = evs_pkg::NUM_TASKS;

  // table memories
  logic [63:0] vr_mem  [N];
  logic [63:0] dl_mem  [N];
  logic [16:0] wt_mem  [N];
  logic [31:0] ord_mem [N];

  logic [N-1:0] vr_vld_r;
  logic [N-1:0] queued_r;

  logic [63:0] vr_q, dl_q;
  logic [16:0] wt_q;
  logic [31:0] ord_q;
  logic        vr_vq;

  logic [1:0]  kind_r;
  logic [5:0]  id_r;
  logic [16:0] w_in_r;
  logic [47:0] rt_r;

  logic [31:0] slice_r, lat_r, ctr_r;
  logic [63:0] min_r;
  logic [22:0] total_r;

  logic [63:0] vsave_r;
  logic [16:0] wdiv_r;
  logic [46:0] p_lo_r, p_hi_r;

  logic [evs_pkg::CNT_W-1:0] issue_r;
  logic [AW-1:0]             ev_idx_r;
  logic                      ev_pend_r;
  logic                      be_found_r, ba_found_r;
  logic [AW-1:0]             be_idx_r, ba_idx_r, best_idx_r;
  logic [63:0]               be_dl_r, ba_dl_r;
  logic [31:0]               be_age_r, ba_age_r;

  logic [1:0]  res_status_r;
  logic [5:0]  res_task_r;
  logic [63:0] res_dl_r;
  logic [1:0]  out_status_r;
  logic [5:0]  out_task_r;
  logic [63:0] out_dl_r;

  logic [AW-1:0] id_addr, rd_addr;
  logic [63:0]   vr_rd, v_enq, sum_q, vdiff;
  logic [63:0]   quot;
  logic          div_done, issue_done, elig, beat_e, beat_a;
  logic [31:0]   age;
  logic [evs_pkg::DIV_W-1:0] prod, dividend;
  logic [16:0]   divisor;
  logic          vr_we, dl_we;
  logic [63:0]   vr_wd, dl_wd;

  assign id_addr    = AW'(id_r);
  assign issue_done = (issue_r == evs_pkg::CNT_W'(N));

  always_comb begin
    if (cmd.rd_scan) begin
      rd_addr = issue_r[AW-1:0];
    end else if (cmd.rd_best) begin
      rd_addr = best_idx_r;
    end else begin
      rd_addr = id_addr;
    end
  end

  assign vr_rd = vr_vq ? vr_q : '0;
  assign v_enq = (vr_rd < min_r) ? min_r : vr_rd;
  assign sum_q = vsave_r + quot;

  assign vr_we = cmd.enq_dec | cmd.chg_fin;
  assign vr_wd = cmd.enq_dec ? v_enq : sum_q;
  assign dl_we = (cmd.enq_dec & (w_in_r == '0)) | cmd.enq_fin;
  assign dl_wd = cmd.enq_fin ? sum_q : v_enq;

  always_ff @(posedge clk) begin
    vr_q  <= vr_mem[rd_addr];
    vr_vq <= vr_vld_r[rd_addr];
    dl_q  <= dl_mem[rd_addr];
    wt_q  <= wt_mem[rd_addr];
    ord_q <= ord_mem[rd_addr];
    if (vr_we) begin
      vr_mem[id_addr] <= vr_wd;
    end
    if (dl_we) begin
      dl_mem[id_addr] <= dl_wd;
    end
    if (cmd.enq_dec) begin
      wt_mem[id_addr]  <= w_in_r;
      ord_mem[id_addr] <= ctr_r;
    end
  end

  // multiply and divide
  assign prod     = evs_pkg::DIV_W'(p_lo_r) + {p_hi_r, 24'b0};
  assign dividend = cmd.div_chg ? prod : evs_pkg::DIV_W'(slice_r);
  assign divisor  = cmd.div_chg ? wdiv_r : w_in_r;

  evs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quot     (quot)
  );

  // scan compare
  always_comb begin
    vdiff  = vr_rd - min_r;
    elig   = (vr_rd <= min_r) || (vdiff <= 64'(lat_r));
    age    = ctr_r - ord_q;
    beat_e = !be_found_r || (dl_q < be_dl_r) || ((dl_q == be_dl_r) && (age > be_age_r));
    beat_a = !ba_found_r || (dl_q < ba_dl_r) || ((dl_q == ba_dl_r) && (age > ba_age_r));
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vr_vld_r   <= '0;
      queued_r   <= '0;
      ctr_r      <= '0;
      min_r      <= '0;
      total_r    <= '0;
      slice_r    <= evs_pkg::SLICE_RST;
      lat_r      <= evs_pkg::LAT_RST;
      issue_r    <= '0;
      ev_pend_r  <= 1'b0;
      be_found_r <= 1'b0;
      ba_found_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          evs_pkg::CFG_SLICE: slice_r <= cfg_wdata;
          evs_pkg::CFG_LAT:   lat_r   <= cfg_wdata;
        endcase
      end
      if (cmd.enq_dec) begin
        vr_vld_r[id_addr] <= 1'b1;
        queued_r[id_addr] <= 1'b1;
        ctr_r             <= ctr_r + 1'b1;
        total_r           <= total_r + 23'(w_in_r);
      end
      if (cmd.deq_do) begin
        queued_r[id_addr] <= 1'b0;
        total_r           <= total_r - 23'(wt_q);
      end
      if (cmd.pick_do) begin
        queued_r[best_idx_r] <= 1'b0;
        total_r              <= total_r - 23'(wt_q);
      end
      if (cmd.chg_fin && (sum_q < min_r)) begin
        min_r <= sum_q;
      end
      ev_pend_r <= 1'b0;
      if (cmd.scan_init) begin
        issue_r    <= '0;
        be_found_r <= 1'b0;
        ba_found_r <= 1'b0;
      end else begin
        if (cmd.rd_scan && !issue_done) begin
          issue_r   <= issue_r + 1'b1;
          ev_pend_r <= 1'b1;
        end
        if (ev_pend_r && queued_r[ev_idx_r]) begin
          if (beat_a) begin
            ba_found_r <= 1'b1;
          end
          if (elig && beat_e) begin
            be_found_r <= 1'b1;
          end
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r       <= in_kind;
      id_r         <= in_task_id;
      w_in_r       <= in_weight;
      rt_r         <= in_runtime;
      res_status_r <= evs_pkg::STS_DONE;
      res_task_r   <= '0;
      res_dl_r     <= '0;
    end
    if (cmd.dec) begin
      vsave_r <= (kind_r == evs_pkg::KIND_ENQ) ? v_enq : vr_rd;
      wdiv_r  <= wt_q;
    end
    if (cmd.mul_lo) begin
      p_lo_r <= rt_r[23:0] * total_r;
    end
    if (cmd.mul_hi) begin
      p_hi_r <= rt_r[47:24] * total_r;
    end
    if (cmd.enq_dec && (w_in_r == '0)) begin
      res_dl_r <= v_enq;
    end
    if (cmd.enq_fin) begin
      res_dl_r <= sum_q;
    end
    if (cmd.set_ign) begin
      res_status_r <= evs_pkg::STS_IGN;
    end
    if (cmd.set_empty) begin
      res_status_r <= evs_pkg::STS_EMPTY;
    end
    if (cmd.rd_scan && !issue_done) begin
      ev_idx_r <= issue_r[AW-1:0];
    end
    if (ev_pend_r && queued_r[ev_idx_r]) begin
      if (beat_a) begin
        ba_idx_r <= ev_idx_r;
        ba_dl_r  <= dl_q;
        ba_age_r <= age;
      end
      if (elig && beat_e) begin
        be_idx_r <= ev_idx_r;
        be_dl_r  <= dl_q;
        be_age_r <= age;
      end
    end
    if (cmd.pick_sel) begin
      best_idx_r <= be_found_r ? be_idx_r : ba_idx_r;
      res_task_r <= 6'(be_found_r ? be_idx_r : ba_idx_r);
      res_dl_r   <= be_found_r ? be_dl_r : ba_dl_r;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_task_r   <= res_task_r;
      out_dl_r     <= res_dl_r;
    end
  end

  always_comb begin
    sts.kind       = kind_r;
    sts.id_ok      = (32'(id_r) < N);
    sts.queued     = queued_r[id_addr];
    sts.w_in_zero  = (w_in_r == '0);
    sts.wt_zero    = (wt_q == '0);
    sts.div_done   = div_done;
    sts.scan_done  = issue_done && !ev_pend_r;
    sts.pick_found = be_found_r | ba_found_r;
  end

  assign out_status          = out_status_r;
  assign out_picked_task     = out_task_r;
  assign out_picked_deadline = out_dl_r;

endmodule

// File: rtl/evs_ctrl.sv
// ----------------------------------------------------------------------------
// EEVDF scheduler controller
// Sequences one command at a time through the datapath and the handshakes.
// ----------------------------------------------------------------------------
module evs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  evs_pkg::dp_sts_t   sts,
  output evs_pkg::dp_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_DEC, S_DIV, S_ENQ_FIN, S_MUL_LO, S_MUL_HI, S_DIV_GO,
    S_CHG_FIN, S_SCAN, S_PICK_SEL, S_PICK_RD, S_PICK_DO, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_RD;
        end
      end
      S_RD: state_nxt = S_DEC;
      S_DEC: begin
        if (sts.kind == evs_pkg::KIND_PICK) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end else if (!sts.id_ok) begin
          cmd.set_ign = 1'b1;
          state_nxt   = S_OUT;
        end else begin
          unique case (sts.kind)
            evs_pkg::KIND_ENQ: begin
              if (sts.queued) begin
                cmd.set_ign = 1'b1;
                state_nxt   = S_OUT;
              end else begin
                cmd.dec     = 1'b1;
                cmd.enq_dec = 1'b1;
                if (sts.w_in_zero) begin
                  state_nxt = S_OUT;
                end else begin
                  cmd.div_start = 1'b1;
                  state_nxt     = S_DIV;
                end
              end
            end
            evs_pkg::KIND_DEQ: begin
              if (sts.queued) begin
                cmd.deq_do = 1'b1;
              end else begin
                cmd.set_ign = 1'b1;
              end
              state_nxt = S_OUT;
            end
            default: begin
              cmd.dec   = 1'b1;
              state_nxt = sts.wt_zero ? S_OUT : S_MUL_LO;
            end
          endcase
        end
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_chg   = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = (sts.kind == evs_pkg::KIND_ENQ) ? S_ENQ_FIN : S_CHG_FIN;
        end
      end
      S_ENQ_FIN: begin
        cmd.enq_fin = 1'b1;
        state_nxt   = S_OUT;
      end
      S_CHG_FIN: begin
        cmd.chg_fin = 1'b1;
        state_nxt   = S_OUT;
      end
      S_SCAN: begin
        cmd.rd_scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_PICK_SEL;
        end
      end
      S_PICK_SEL: begin
        if (sts.pick_found) begin
          cmd.pick_sel = 1'b1;
          state_nxt    = S_PICK_RD;
        end else begin
          cmd.set_empty = 1'b1;
          state_nxt     = S_OUT;
        end
      end
      S_PICK_RD: begin
        cmd.rd_best = 1'b1;
        state_nxt   = S_PICK_DO;
      end
      S_PICK_DO: begin
        cmd.pick_do = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        // hold until the output slot is free
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = (out_valid_r & out_stall) | cmd.out_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: rtl/eevdf_task_scheduler.sv
// ----------------------------------------------------------------------------
// EEVDF task scheduler
// Task table; picks earliest eligible virtual deadline, else earliest overall.
// ----------------------------------------------------------------------------
// Flow per item: dequeue and ignored items go straight to the result; enqueue
//   runs the divider (not when weight is zero); charge runs the 71-step
//   bit-serial divider; pick runs the one-entry-per-cycle scan of the task
//   table read port, then reads and removes the best task (not when empty).
// Items are taken one at a time; the output register lets the next item start
//   while a result waits.
// Reset: synchronous, active low; queue and valid bits clear at once, no sweep.
module eevdf_task_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [5:0]  in_task_id,
  input  logic [16:0] in_weight,
  input  logic [47:0] in_runtime,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [5:0]  out_picked_task,
  output logic [63:0] out_picked_deadline,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  evs_pkg::dp_cmd_t cmd;
  evs_pkg::dp_sts_t sts;

  evs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  evs_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_kind             (in_kind),
    .in_task_id          (in_task_id),
    .in_weight           (in_weight),
    .in_runtime          (in_runtime),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .out_status          (out_status),
    .out_picked_task     (out_picked_task),
    .out_picked_deadline (out_picked_deadline)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted while another is in flight");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != 2'd3))
    else $error("undefined status code");

  a_fail_no_deadline: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != evs_pkg::STS_DONE)) |->
      ((out_picked_deadline == '0) && (out_picked_task == '0)))
    else $error("failed command carries a deadline or task");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_picked_deadline))
    else $error("result overwritten while waiting");

endmodule
